// File: rtl/multi_source_edge_relaxation_core_assert.svh
// Assertion helpers shared by the core's modules
`ifndef MULTI_SOURCE_EDGE_RELAXATION_CORE_ASSERT_SVH
`define MULTI_SOURCE_EDGE_RELAXATION_CORE_ASSERT_SVH

// Property checked on every clock edge outside reset
`define MSER_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked on every clock edge, reset included
`define MSER_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/mser_pkg.sv
`timescale 1ns / 1ps
package mser_pkg;

  typedef enum logic [1:0] {
    OP_RELAX     = 2'd0,
    OP_END_ROUND = 2'd1,
    OP_SEED      = 2'd2,
    OP_READ      = 2'd3
  } op_t;

  localparam logic [31:0] UNREACHABLE = 32'hFFFF_FFFF;
  localparam logic [15:0] CNT_MAX     = 16'hFFFF;

  // controller -> datapath
  typedef struct packed {
    logic cap;         // capture input transaction
    logic sweep_init;  // reset clear: distances to unreachable, frontiers to zero
    logic sweep_clr;   // end round: clear current frontier bank
    logic rd_src;      // read address = source vertex
    logic rd_dst;      // read address = destination, latch source row
    logic exec;        // compute and write back
    logic round_end;   // report counter, clear it, swap banks
    logic load_out;    // move result into output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic sweep_last;
    logic out_busy;
  } dp_stat_t;

endpackage

// File: rtl/mser_datapath.sv
`timescale 1ns / 1ps
`include "multi_source_edge_relaxation_core_assert.svh"
module mser_datapath #(
  parameter int NUM_SEARCHES = 8,
  parameter int NUM_VERTICES = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  mser_pkg::dp_cmd_t   cmd,
  output mser_pkg::dp_stat_t  stat,
  input  logic [1:0]          op,
  input  logic [9:0]          from_vertex,
  input  logic [9:0]          to_vertex,
  input  logic [15:0]         edge_weight,
  input  logic [2:0]          search_index,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          improved_mask,
  output logic                improved_any,
  output logic [15:0]         round_improvements,
  output logic                more_rounds,
  output logic [31:0]         distance_value
);

  localparam int AW = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
  localparam int NS = NUM_SEARCHES;

  // captured transaction
  mser_pkg::op_t    op_q;
  logic [AW-1:0]    from_a;
  logic [AW-1:0]    to_a;
  logic             edge_ok;
  logic             to_ok;
  logic             srch_ok;
  logic [2:0]       srch_q;
  logic [15:0]      weight_q;

  // state
  logic             bank_select;
  logic [15:0]      improve_counter;
  logic [AW-1:0]    sweep_idx;

  // memories: one distance lane per search, two frontier banks
  logic [31:0]      lane_q   [NS];
  logic [31:0]      src_dist [NS];
  logic [NS-1:0]    src_act;
  logic [NS-1:0]    fr0 [NUM_VERTICES];
  logic [NS-1:0]    fr1 [NUM_VERTICES];
  logic [NS-1:0]    fr0_q;
  logic [NS-1:0]    fr1_q;

  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;
  logic [NS-1:0]    lane_we;
  logic [31:0]      lane_wd  [NS];
  logic [31:0]      cand     [NS];
  logic [NS-1:0]    imp;
  logic [NS-1:0]    seed_bit;
  logic [NS-1:0]    cur_q;
  logic [NS-1:0]    nxt_q;
  logic             fr0_we;
  logic             fr1_we;
  logic [NS-1:0]    fr0_wd;
  logic [NS-1:0]    fr1_wd;
  logic [31:0]      sel_dist;

  // results
  logic [NS-1:0]    res_mask;
  logic [15:0]      res_cnt;
  logic [31:0]      res_dist;

  assign stat.sweep_last = (sweep_idx == AW'(NUM_VERTICES - 1));
  assign stat.out_busy   = out_valid && !out_ready;

  assign rd_addr = cmd.rd_src ? from_a : to_a;
  assign wr_addr = (cmd.sweep_init || cmd.sweep_clr) ? sweep_idx : to_a;
  assign cur_q   = bank_select ? fr1_q : fr0_q;
  assign nxt_q   = bank_select ? fr0_q : fr1_q;

  // per-lane candidate, improvement and seed decode
  always_comb begin
    sel_dist = mser_pkg::UNREACHABLE;
    for (int i = 0; i < NS; i++) begin
      logic [32:0] sum;
      sum         = {1'b0, src_dist[i]} + {17'd0, weight_q};
      cand[i]     = sum[32] ? mser_pkg::UNREACHABLE : sum[31:0];
      imp[i]      = edge_ok && src_act[i] && (cand[i] < lane_q[i]);
      seed_bit[i] = to_ok && srch_ok && (srch_q == 3'(i));
      if (srch_q == 3'(i)) begin
        sel_dist = lane_q[i];
      end
    end
  end

  // distance lane write control
  always_comb begin
    for (int i = 0; i < NS; i++) begin
      lane_we[i] = 1'b0;
      lane_wd[i] = mser_pkg::UNREACHABLE;
      if (cmd.sweep_init) begin
        lane_we[i] = 1'b1;
      end else if (cmd.exec && op_q == mser_pkg::OP_RELAX) begin
        lane_we[i] = imp[i];
        lane_wd[i] = cand[i];
      end else if (cmd.exec && op_q == mser_pkg::OP_SEED) begin
        lane_we[i] = seed_bit[i];
        lane_wd[i] = 32'd0;
      end
    end
  end

  // frontier write control
  always_comb begin
    fr0_we = 1'b0;
    fr1_we = 1'b0;
    fr0_wd = '0;
    fr1_wd = '0;
    if (cmd.sweep_init) begin
      fr0_we = 1'b1;
      fr1_we = 1'b1;
    end else if (cmd.sweep_clr) begin
      fr0_we = !bank_select;
      fr1_we = bank_select;
    end else if (cmd.exec && op_q == mser_pkg::OP_RELAX && (|imp)) begin
      fr0_we = bank_select;
      fr1_we = !bank_select;
      fr0_wd = nxt_q | imp;
      fr1_wd = nxt_q | imp;
    end else if (cmd.exec && op_q == mser_pkg::OP_SEED && (|seed_bit)) begin
      fr0_we = !bank_select;
      fr1_we = bank_select;
      fr0_wd = cur_q | seed_bit;
      fr1_wd = cur_q | seed_bit;
    end
  end

  // distance lanes
  for (genvar g = 0; g < NS; g++) begin : g_lane
    logic [31:0] mem [NUM_VERTICES];
    always_ff @(posedge clk) begin
      if (lane_we[g]) begin
        mem[wr_addr] <= lane_wd[g];
      end
      lane_q[g] <= mem[rd_addr];
    end
  end

  // frontier banks
  always_ff @(posedge clk) begin
    if (fr0_we) begin
      fr0[wr_addr] <= fr0_wd;
    end
    if (fr1_we) begin
      fr1[wr_addr] <= fr1_wd;
    end
    fr0_q <= fr0[rd_addr];
    fr1_q <= fr1[rd_addr];
  end

  // transaction capture and source row latch
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      op_q     <= mser_pkg::op_t'(op);
      from_a   <= AW'(from_vertex);
      to_a     <= AW'(to_vertex);
      edge_ok  <= (32'(from_vertex) < NUM_VERTICES) && (32'(to_vertex) < NUM_VERTICES);
      to_ok    <= (32'(to_vertex) < NUM_VERTICES);
      srch_ok  <= (32'(search_index) < NS);
      srch_q   <= search_index;
      weight_q <= edge_weight;
    end
    if (cmd.rd_dst) begin
      for (int i = 0; i < NS; i++) begin
        src_dist[i] <= lane_q[i];
      end
      src_act <= cur_q;
    end
  end

  // result staging
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      res_mask <= '0;
      res_cnt  <= '0;
      res_dist <= '0;
    end else if (cmd.exec) begin
      if (op_q == mser_pkg::OP_RELAX) begin
        res_mask <= imp;
      end else if (op_q == mser_pkg::OP_READ) begin
        res_dist <= (to_ok && srch_ok) ? sel_dist : mser_pkg::UNREACHABLE;
      end
    end else if (cmd.round_end) begin
      res_cnt <= improve_counter;
    end
  end

  // control state: bank select, counter, sweep index, output register
  always_ff @(posedge clk) begin
    if (rst) begin
      bank_select     <= 1'b0;
      improve_counter <= '0;
      sweep_idx       <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cmd.sweep_init || cmd.sweep_clr) begin
        sweep_idx <= stat.sweep_last ? '0 : sweep_idx + AW'(1);
      end
      if (cmd.round_end) begin
        bank_select     <= !bank_select;
        improve_counter <= '0;
      end else if (cmd.exec && op_q == mser_pkg::OP_RELAX && (|imp) &&
                   improve_counter != mser_pkg::CNT_MAX) begin
        improve_counter <= improve_counter + 16'd1;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      improved_mask      <= 8'(res_mask);
      improved_any       <= |res_mask;
      round_improvements <= res_cnt;
      more_rounds        <= |res_cnt;
      distance_value     <= res_dist;
    end
  end

  `MSER_ASSERT(a_any_matches_mask, out_valid |-> (improved_any == (|improved_mask)), "improved_any disagrees with mask")
  `MSER_ASSERT(a_result_kinds_exclusive, out_valid |-> !(improved_any && more_rounds), "relax and round results mixed")
  `MSER_ASSERT(a_no_exec_during_sweep, !(cmd.exec && (cmd.sweep_init || cmd.sweep_clr)), "write-back collides with sweep")

endmodule

// File: rtl/mser_ctrl.sv
`timescale 1ns / 1ps
`include "multi_source_edge_relaxation_core_assert.svh"
module mser_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         op,
  input  mser_pkg::dp_stat_t stat,
  output mser_pkg::dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_RD_SRC,
    S_RD_DST,
    S_EXEC,
    S_CLEAR,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // command decode and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_INIT: begin
        cmd.sweep_init = 1'b1;
        if (stat.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.cap = accept;
        if (accept) begin
          case (mser_pkg::op_t'(op))
            mser_pkg::OP_RELAX:     state_next = S_RD_SRC;
            mser_pkg::OP_END_ROUND: state_next = S_CLEAR;
            default:                state_next = S_RD_DST;
          endcase
        end
      end
      S_RD_SRC: begin
        cmd.rd_src = 1'b1;
        state_next = S_RD_DST;
      end
      S_RD_DST: begin
        cmd.rd_dst = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_DONE;
      end
      S_CLEAR: begin
        cmd.sweep_clr = 1'b1;
        if (stat.sweep_last) begin
          cmd.round_end = 1'b1;
          state_next    = S_DONE;
        end
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  `MSER_ASSERT(a_one_in_flight, accept |=> !in_ready, "second transaction taken while busy")
  `MSER_ASSERT(a_clear_ends_round, (state == S_CLEAR && stat.sweep_last) |=> state == S_DONE, "round end skipped")
  `MSER_ASSERT(a_exec_after_dst, cmd.exec |-> $past(cmd.rd_dst), "write-back without destination read")

endmodule

// File: rtl/multi_source_edge_relaxation_core.sv
`timescale 1ns / 1ps
// Eight-way shortest-path relaxation engine. Each transaction on the input
// channel returns exactly one result transaction. Items are handled one at a
// time, and all distance lanes share one read port, so a relax steps through
// source row read, destination row read, compare and write back, and result
// load after acceptance; seed or read skip the source row read. End of round
// sweeps the current frontier bank one vertex per cycle. After reset a
// clearing pass sets every distance to unreachable and both frontier
// banks to zero; no input is taken meanwhile.
// A finished result waits in the output register; the next item is accepted
// while it waits and stalls only at its own result load.
module multi_source_edge_relaxation_core #(
  parameter int NUM_SEARCHES = 8,
  parameter int NUM_VERTICES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [9:0]  from_vertex,
  input  logic [9:0]  to_vertex,
  input  logic [15:0] edge_weight,
  input  logic [2:0]  search_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  improved_mask,
  output logic        improved_any,
  output logic [15:0] round_improvements,
  output logic        more_rounds,
  output logic [31:0] distance_value
);

  mser_pkg::dp_cmd_t  cmd;
  mser_pkg::dp_stat_t stat;

  mser_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .op       (op),
    .stat     (stat),
    .cmd      (cmd)
  );

  mser_datapath #(
    .NUM_SEARCHES (NUM_SEARCHES),
    .NUM_VERTICES (NUM_VERTICES)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .stat               (stat),
    .op                 (op),
    .from_vertex        (from_vertex),
    .to_vertex          (to_vertex),
    .edge_weight        (edge_weight),
    .search_index       (search_index),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .improved_mask      (improved_mask),
    .improved_any       (improved_any),
    .round_improvements (round_improvements),
    .more_rounds        (more_rounds),
    .distance_value     (distance_value)
  );

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  localparam int NSRCH = 8;
  localparam int NVERT = 1024;

  // Expected result of one transaction
  typedef struct packed {
    logic [7:0]  mask;
    logic        any_imp;
    logic [15:0] round_cnt;
    logic        more;
    logic [31:0] dist_val;
  } relax_result_t;

  // Shadow of the engine state plus queue of pending results
  class relax_scoreboard;
    logic [31:0] dist_mem [NSRCH*NVERT];
    logic [7:0]  front [2][NVERT];
    bit          cur_bank;
    int unsigned imp_count;
    relax_result_t pending [$];
    int errors;
    int relax_hits;
    int rounds_seen;

    function void init();
      foreach (dist_mem[i]) dist_mem[i] = mser_pkg::UNREACHABLE;
      foreach (front[b, v]) front[b][v] = '0;
      cur_bank = 0;
      imp_count = 0;
      errors = 0;
      relax_hits = 0;
      rounds_seen = 0;
    endfunction

    // Apply one accepted input transaction to the shadow state
    function void note_input(mser_pkg::op_t o, int fv, int tv, logic [15:0] w, int s);
      relax_result_t r;
      logic [32:0] cand;
      logic [31:0] c32;
      r = '0;
      case (o)
        mser_pkg::OP_RELAX: begin
          for (int i = 0; i < NSRCH; i++) begin
            if (front[cur_bank][fv][i]) begin
              cand = {1'b0, dist_mem[i*NVERT+fv]} + {17'd0, w};
              c32 = cand[32] ? mser_pkg::UNREACHABLE : cand[31:0];
              if (c32 < dist_mem[i*NVERT+tv]) begin
                dist_mem[i*NVERT+tv] = c32;
                front[!cur_bank][tv][i] = 1'b1;
                r.mask[i] = 1'b1;
              end
            end
          end
          r.any_imp = |r.mask;
          if (r.any_imp) begin
            relax_hits++;
            if (imp_count < 16'hFFFF) imp_count++;
          end
        end
        mser_pkg::OP_END_ROUND: begin
          r.round_cnt = imp_count[15:0];
          r.more = imp_count != 0;
          for (int v = 0; v < NVERT; v++) front[cur_bank][v] = '0;
          cur_bank = !cur_bank;
          imp_count = 0;
          rounds_seen++;
        end
        mser_pkg::OP_SEED: begin
          dist_mem[s*NVERT+tv] = '0;
          front[cur_bank][tv][s] = 1'b1;
        end
        default: r.dist_val = dist_mem[s*NVERT+tv];
      endcase
      pending.push_back(r);
    endfunction

    // Compare one output transaction against the oldest expectation
    task check_result(relax_result_t got);
      relax_result_t e;
      if (pending.size() == 0) begin
        report_err("result with nothing expected");
        return;
      end
      e = pending.pop_front();
      if (got.mask !== e.mask)
        report_err($sformatf("improved_mask %h exp %h", got.mask, e.mask));
      if (got.any_imp !== e.any_imp)
        report_err($sformatf("improved_any %b exp %b", got.any_imp, e.any_imp));
      if (got.round_cnt !== e.round_cnt)
        report_err($sformatf("round_improvements %0d exp %0d", got.round_cnt, e.round_cnt));
      if (got.more !== e.more)
        report_err($sformatf("more_rounds %b exp %b", got.more, e.more));
      if (got.dist_val !== e.dist_val)
        report_err($sformatf("distance_value %h exp %h", got.dist_val, e.dist_val));
    endtask

    task report_err(string msg);
      errors++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] op = '0;
  logic [9:0] from_vertex = '0;
  logic [9:0] to_vertex = '0;
  logic [15:0] edge_weight = '0;
  logic [2:0] search_index = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [7:0] improved_mask;
  logic improved_any;
  logic [15:0] round_improvements;
  logic more_rounds;
  logic [31:0] distance_value;

  relax_scoreboard sb;
  bit hold_sink = 0;
  int n_sent = 0;

  multi_source_edge_relaxation_core dut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // Send one transaction after a random gap
  task automatic send_item(mser_pkg::op_t o, int fv, int tv, int w, int s);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    from_vertex <= 10'(fv);
    to_vertex <= 10'(tv);
    edge_weight <= w[15:0];
    search_index <= 3'(s);
    do @(posedge clk); while (!in_ready);
    sb.note_input(o, fv, tv, w[15:0], s);
    n_sent++;
  endtask

  // Random item over a small graph so frontiers propagate
  task automatic send_random();
    int pick;
    int fv;
    int tv;
    pick = $urandom_range(0, 99);
    fv = $urandom_range(0, 5) == 0 ? $urandom_range(0, NVERT-1) : $urandom_range(0, 31);
    tv = $urandom_range(0, 5) == 0 ? $urandom_range(0, NVERT-1) : $urandom_range(0, 31);
    if (pick < 65)
      send_item(mser_pkg::OP_RELAX, fv, tv,
                $urandom_range(0, 7) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 300),
                $urandom_range(0, 7));
    else if (pick < 72) send_item(mser_pkg::OP_END_ROUND, fv, tv, $urandom_range(0, 65535),
                                  $urandom_range(0, 7));
    else if (pick < 80) send_item(mser_pkg::OP_SEED, fv, tv, $urandom_range(0, 65535),
                                  $urandom_range(0, 7));
    else send_item(mser_pkg::OP_READ, fv, tv, $urandom_range(0, 65535), $urandom_range(0, 7));
  endtask

  // Receiver: random wait per transaction, plus the long hold-off when requested
  initial begin
    relax_result_t got;
    int gap;
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
      if (hold_sink && gap == 0) gap = 1;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
        while (hold_sink) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got.mask = improved_mask;
      got.any_imp = improved_any;
      got.round_cnt = round_improvements;
      got.more = more_rounds;
      got.dist_val = distance_value;
      sb.check_result(got);
    end
  end

  // Long receiver hold-off, counted in its own process
  initial begin
    wait (n_sent == 300);
    hold_sink = 1;
    repeat (400) @(posedge clk);
    hold_sink = 0;
  end

  initial begin
    #30_000_000;
    $display("tb_top failed");
    $finish;
  end

  initial begin
    int w;
    sb = new();
    sb.init();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    // Directed: seeds, chains, saturation, self loop, inactive source
    send_item(mser_pkg::OP_READ, 0, 1023, 0, 7);
    send_item(mser_pkg::OP_SEED, 0, 0, 0, 0);
    send_item(mser_pkg::OP_SEED, 0, 1023, 0, 7);
    send_item(mser_pkg::OP_RELAX, 0, 5, 65535, 0);
    send_item(mser_pkg::OP_RELAX, 1023, 1023, 65535, 0);
    send_item(mser_pkg::OP_RELAX, 1023, 3, 0, 0);
    send_item(mser_pkg::OP_RELAX, 0, 0, 0, 0);
    send_item(mser_pkg::OP_RELAX, 7, 8, 10, 0);
    send_item(mser_pkg::OP_RELAX, 0, 5, 100, 0);
    send_item(mser_pkg::OP_END_ROUND, 0, 0, 0, 0);
    send_item(mser_pkg::OP_RELAX, 5, 6, 1, 0);
    send_item(mser_pkg::OP_RELAX, 3, 1, 16'hFFFF, 0);
    send_item(mser_pkg::OP_READ, 0, 5, 0, 0);
    send_item(mser_pkg::OP_READ, 0, 6, 0, 0);
    send_item(mser_pkg::OP_READ, 0, 3, 0, 7);
    send_item(mser_pkg::OP_END_ROUND, 0, 0, 0, 0);
    send_item(mser_pkg::OP_END_ROUND, 0, 0, 0, 0);
    send_item(mser_pkg::OP_SEED, 0, 2, 0, 3);
    send_item(mser_pkg::OP_READ, 0, 2, 0, 3);
    // Random phase: each burst reseeds then runs relax rounds
    while (n_sent < 1420) begin
      for (int k = 0; k < 4; k++)
        send_item(mser_pkg::OP_SEED, 0, $urandom_range(0, 31), 0, $urandom_range(0, 7));
      for (int k = 0; k < 60; k++) send_random();
    end
    // Drain with counter pushed to saturation is impractical; also cover wide weights
    w = 65535;
    send_item(mser_pkg::OP_RELAX, 1023, 0, w, 7);
    send_item(mser_pkg::OP_END_ROUND, 1023, 1023, w, 7);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d transactions: %0d improving relaxes over %0d rounds.",
             n_sent, sb.relax_hits, sb.rounds_seen);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end
endmodule

// File: files.f
+incdir+rtl
rtl/mser_pkg.sv
rtl/mser_datapath.sv
rtl/mser_ctrl.sv
rtl/multi_source_edge_relaxation_core.sv
tb/sv/tb_top.sv
